// ===== rtl/wlps_pkg.sv =====
package wlps_pkg;

  localparam int DATA_W             = 16;
  localparam int LEVEL_W            = 8;
  localparam int DIVIDEND_W         = DATA_W + LEVEL_W;
  localparam int COUNT_W            = $clog2(LEVEL_W + 1);
  localparam int PIXEL_BITS_DEFAULT = 16;
  localparam int APB_DATA_W         = 32;
  localparam int APB_ADDR_W         = 3;

  localparam logic [LEVEL_W-1:0]    LEVEL_MAX  = '1;
  localparam logic [LEVEL_W-1:0]    LEVEL_ZERO = '0;

  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_LOW  = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_HIGH = 3'd4;

  localparam logic signed [DATA_W-1:0] WINDOW_LOW_RESET  = 16'sd0;
  localparam logic signed [DATA_W-1:0] WINDOW_HIGH_RESET = 16'sd32767;

  typedef enum logic [1:0] {
    SEL_ZERO   = 2'd0,
    SEL_FULL   = 2'd1,
    SEL_SCALED = 2'd2
  } level_sel_t;

  typedef struct packed {
    logic start;
    logic take;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/window_level_pixel_scaler_core.sv =====
// Window-level pixel scaler. Each request carries one signed pixel and a restart
// flag and yields one 8-bit intensity together with the running minimum and maximum
// of the pixels seen since the last restart (or since reset). Pixels above
// window_high give 255, pixels below window_low give 0, and the rest give
// floor((pixel - window_low) * 255 / range), where range is window_high - window_low,
// or 1 when the bounds are equal. The quotient comes from a bit-serial restoring
// divider that produces one bit per cycle; once all eight quotient bits are formed,
// the result enters the output register when that register is empty or being
// taken, and the block then returns to idle and can accept the next request in the
// cycle after that; one request is in flight at a time, and the output register
// lets the next request be accepted while a result waits to be taken. The window
// registers sit at byte addresses 0 (window_low) and 4 (window_high) of the APB
// port and should be written only while the block is idle.
module window_level_pixel_scaler_core
  import wlps_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready,
  input  logic                     pixel_valid,
  output logic                     pixel_stall,
  input  logic signed [DATA_W-1:0] pixel,
  input  logic                     restart,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [LEVEL_W-1:0]       intensity,
  output logic signed [DATA_W-1:0] seen_min,
  output logic signed [DATA_W-1:0] seen_max
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                        state;
  logic                        state_next;
  logic signed [DATA_W-1:0]    window_low;
  logic signed [DATA_W-1:0]    window_high;
  logic signed [PIXEL_BITS-1:0] pix_raw;
  logic signed [DATA_W-1:0]    pix;
  logic [DATA_W:0]             offset;
  logic [DATA_W:0]             span;
  logic [DATA_W-1:0]           divisor;
  logic [DIVIDEND_W-1:0]       dividend;
  logic                        accept;
  logic                        deliver;
  level_sel_t                  level_sel;
  level_sel_t                  level_sel_next;
  div_ctrl_t                   div_ctrl;
  div_status_t                 div_status;
  logic [LEVEL_W-1:0]          quotient;
  logic signed [DATA_W-1:0]    track_min;
  logic signed [DATA_W-1:0]    track_max;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low  <= WINDOW_LOW_RESET;
      window_high <= WINDOW_HIGH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ADDR_WINDOW_LOW:  window_low  <= pwdata[DATA_W-1:0];
        ADDR_WINDOW_HIGH: window_high <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_WINDOW_LOW:  prdata = APB_DATA_W'(window_low);
      ADDR_WINDOW_HIGH: prdata = APB_DATA_W'(window_high);
      default:          prdata = '0;
    endcase
  end

  assign pix_raw = pixel[PIXEL_BITS-1:0];
  assign pix     = DATA_W'(pix_raw);
  assign offset  = (DATA_W+1)'(pix) - (DATA_W+1)'(window_low);
  assign span    = (DATA_W+1)'(window_high) - (DATA_W+1)'(window_low);
  assign divisor = (span[DATA_W-1:0] == '0) ? DATA_W'(1) : span[DATA_W-1:0];
  assign dividend = {offset[DATA_W-1:0], {LEVEL_W{1'b0}}}
                  - DIVIDEND_W'(offset[DATA_W-1:0]);

  always_comb begin
    if (pix > window_high) begin
      level_sel_next = SEL_FULL;
    end else if (pix < window_low) begin
      level_sel_next = SEL_ZERO;
    end else begin
      level_sel_next = SEL_SCALED;
    end
  end

  assign pixel_stall = (state != ST_IDLE);
  assign accept      = pixel_valid && !pixel_stall;
  assign deliver     = (state == ST_DIV) && div_status.done
                    && (!result_valid || !result_stall);

  assign div_ctrl.start = accept;
  assign div_ctrl.take  = deliver;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_DIV;
      ST_DIV:  if (deliver) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      level_sel <= level_sel_next;
    end
  end

  wlps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (dividend),
    .divisor  (divisor),
    .status   (div_status),
    .quotient (quotient)
  );

  wlps_track u_track (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .restart  (restart),
    .pixel    (pix),
    .seen_min (track_min),
    .seen_max (track_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (deliver) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      seen_min <= track_min;
      seen_max <= track_max;
      case (level_sel)
        SEL_FULL:   intensity <= LEVEL_MAX;
        SEL_SCALED: intensity <= quotient;
        default:    intensity <= LEVEL_ZERO;
      endcase
    end
  end

endmodule

// ===== rtl/wlps_div.sv =====
module wlps_div
  import wlps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  div_ctrl_t               ctrl,
  input  logic [DIVIDEND_W-1:0]   dividend,
  input  logic [DATA_W-1:0]       divisor,
  output div_status_t             status,
  output logic [LEVEL_W-1:0]      quotient
);

  logic                 active;
  logic [COUNT_W-1:0]   count;
  logic [DATA_W-1:0]    rem;
  logic [LEVEL_W-1:0]   bits;
  logic [DATA_W-1:0]    div_reg;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      trial;
  logic                 fits;

  assign shifted = {rem, bits[LEVEL_W-1]};
  assign trial   = shifted - {1'b0, div_reg};
  assign fits    = shifted >= {1'b0, div_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count  <= '0;
    end else if (ctrl.start) begin
      active <= 1'b1;
      count  <= COUNT_W'(LEVEL_W);
    end else if (ctrl.take) begin
      active <= 1'b0;
    end else if (active && count != '0) begin
      count <= count - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem      <= dividend[DIVIDEND_W-1:LEVEL_W];
      bits     <= dividend[LEVEL_W-1:0];
      div_reg  <= divisor;
      quotient <= '0;
    end else if (active && count != '0) begin
      rem      <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      bits     <= {bits[LEVEL_W-2:0], 1'b0};
      quotient <= {quotient[LEVEL_W-2:0], fits};
    end
  end

  assign status.busy = active;
  assign status.done = active && (count == '0);

endmodule

// ===== rtl/wlps_track.sv =====
module wlps_track
  import wlps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     restart,
  input  logic signed [DATA_W-1:0] pixel,
  output logic signed [DATA_W-1:0] seen_min,
  output logic signed [DATA_W-1:0] seen_max
);

  logic seeded;

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded   <= 1'b0;
      seen_min <= '0;
      seen_max <= '0;
    end else if (accept) begin
      seeded <= 1'b1;
      if (restart || !seeded) begin
        seen_min <= pixel;
        seen_max <= pixel;
      end else if (pixel < seen_min) begin
        seen_min <= pixel;
      end else if (pixel > seen_max) begin
        seen_max <= pixel;
      end
    end
  end

endmodule
